// ----- hdl/b73enc_pkg.sv -----
// Package for the base-73 word-to-text encoder.
// Holds the radix, the divider step sizes, the state codes and the digit-to-character table.
// Depends on nothing.
package b73enc_pkg;

    localparam int WORD_W  = 63;
    localparam int WORK_W  = 64;
    localparam int CHUNK_W = 8;
    localparam int STEPS   = WORK_W / CHUNK_W;
    localparam int STEP_W  = $clog2(STEPS);
    localparam int RADIX   = 73;
    localparam int REM_W   = 7;
    localparam int CHAR_W  = 7;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    typedef logic [1:0] t_state;

    localparam logic [8*RADIX-1:0] DIGIT_STR =
        "uMKJNPpA1Yh0)f6_x3WU<>SgQ4wbDizV5dc9t2XZ?(/7*s.FEHvLG8yRTkej-OlB+armnoqCI";

    // The first character of the string sits in the top byte.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
        logic [9:0] pos;
        pos = 10'(8) * (10'(RADIX - 1) - 10'(d));
        return DIGIT_STR[pos +: CHAR_W];
    endfunction

endpackage

// ----- hdl/base73_word_to_text_encoder.sv -----
// Top level of the base-73 word-to-text encoder: sequencer, shared divide-by-73 unit
// and output register. Depends on b73enc_pkg.
//
// Usage: the input channel takes one beat holding a 63-bit word and a pad flag. The
// block answers with one output beat per base-73 digit, least significant digit
// first, each carrying the 7-bit ASCII code of the digit's table character. The last
// beat of a word has last_char set; it also has overflow set when digits remained
// after MAX_DIGITS characters. A zero word without padding gives no beats at all.
// With padding exactly MAX_DIGITS beats are sent.
// One shared unit divides the 64-bit work register by 73, eight bits per cycle, in
// state S_DIV; state S_EMIT then loads the digit's character into the output
// register, waiting there while the receiver stalls. After acceptance the sequencer
// passes through S_DIV and then S_EMIT for each character of the word.
// For a word that yields characters, o_in_stall is high from the cycle after
// acceptance until its last character has been loaded into the output register.
// The next word may be taken while that last beat still waits.
// A stall from the receiver holds the output beat unchanged and pauses the sequencer
// before its next load; the following digit is already computed meanwhile.
// Reset clears the sequencer and the output valid; no beat is pending afterward.
module base73_word_to_text_encoder #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [b73enc_pkg::WORD_W-1:0]    i_word_value,
    input  logic                             i_pad_full,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [b73enc_pkg::CHAR_W-1:0]    o_out_char,
    output logic                             o_last_char,
    output logic                             o_overflow
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    b73enc_pkg::t_state                    r_state, n_state;
    logic [b73enc_pkg::STEP_W-1:0]         r_step, n_step;
    logic [CNT_W-1:0]                      r_cnt, n_cnt;
    logic                                  r_out_valid, n_out_valid;
    logic [b73enc_pkg::WORK_W-1:0]         r_work, n_work;
    logic [b73enc_pkg::REM_W-1:0]          r_rem, n_rem;
    logic                                  r_pad, n_pad;
    logic [b73enc_pkg::CHAR_W-1:0]         r_char, n_char;
    logic                                  r_last, n_last;
    logic                                  r_ovf, n_ovf;

    logic [b73enc_pkg::CHUNK_W-1:0]        div_chunk;
    logic [b73enc_pkg::CHUNK_W-1:0]        div_quot;
    logic [b73enc_pkg::REM_W-1:0]          div_rem;
    logic [b73enc_pkg::REM_W:0]            div_part;
    logic                                  q_zero;
    logic                                  is_last;
    logic                                  slot_free;
    logic                                  in_accept;

    assign o_in_stall  = (r_state != b73enc_pkg::S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;
    assign o_overflow  = r_ovf;

    // Restoring division of the running remainder and eight new dividend bits by 73.
    always_comb begin
        div_chunk = r_work[b73enc_pkg::WORK_W-1 -: b73enc_pkg::CHUNK_W];
        div_rem   = r_rem;
        div_quot  = '0;
        div_part  = '0;
        for (int i = b73enc_pkg::CHUNK_W - 1; i >= 0; i--) begin
            div_part = {div_rem, div_chunk[i]};
            if (div_part >= (b73enc_pkg::REM_W + 1)'(b73enc_pkg::RADIX)) begin
                div_part    = div_part - (b73enc_pkg::REM_W + 1)'(b73enc_pkg::RADIX);
                div_quot[i] = 1'b1;
            end
            div_rem = div_part[b73enc_pkg::REM_W-1:0];
        end
    end

    assign q_zero    = (r_work == '0);
    assign is_last   = (q_zero && !r_pad) || (r_cnt == CNT_W'(MAX_DIGITS - 1));
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_work      = r_work;
        n_rem       = r_rem;
        n_pad       = r_pad;
        n_char      = r_char;
        n_last      = r_last;
        n_ovf       = r_ovf;
        unique case (r_state)
            b73enc_pkg::S_IDLE: begin
                if (in_accept && ((i_word_value != '0) || i_pad_full)) begin
                    n_work  = {1'b0, i_word_value};
                    n_pad   = i_pad_full;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_step  = '0;
                    n_state = b73enc_pkg::S_DIV;
                end
            end
            b73enc_pkg::S_DIV: begin
                n_work = {r_work[b73enc_pkg::WORK_W-b73enc_pkg::CHUNK_W-1:0], div_quot};
                n_rem  = div_rem;
                n_step = r_step + 1'b1;
                if (r_step == b73enc_pkg::STEP_W'(b73enc_pkg::STEPS - 1)) begin
                    n_state = b73enc_pkg::S_EMIT;
                end
            end
            b73enc_pkg::S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = b73enc_pkg::digit_char(r_rem);
                    n_last      = is_last;
                    n_ovf       = is_last && !q_zero;
                    n_rem       = '0;
                    n_step      = '0;
                    n_cnt       = r_cnt + 1'b1;
                    n_state     = is_last ? b73enc_pkg::S_IDLE : b73enc_pkg::S_DIV;
                end
            end
            default: begin
                n_state = b73enc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= b73enc_pkg::S_IDLE;
            r_step      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_pad  <= n_pad;
        r_char <= n_char;
        r_last <= n_last;
        r_ovf  <= n_ovf;
    end

endmodule

// ----- hdl/b73enc_chk.sv -----
// Port-level checker for the base-73 word-to-text encoder, bound to its top level.
// Depends on b73enc_pkg for field widths.
module b73enc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [b73enc_pkg::WORD_W-1:0] i_word_value,
    input logic                          i_pad_full,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [b73enc_pkg::CHAR_W-1:0] o_out_char,
    input logic                          o_last_char,
    input logic                          o_overflow
);

    // A stalled output beat stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_char) && $stable(o_last_char) && $stable(o_overflow))
        else $error("stalled output beat changed");

    // Overflow is only flagged on the last character of a word.
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_last_char)
        else $error("overflow on a character that is not last");

    // A word that yields characters makes the block busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && ((i_word_value != '0) || i_pad_full) |=> o_in_stall)
        else $error("block not busy after taking a word");

    // While ready for a new word, only a final character may be waiting.
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall && o_out_valid |-> o_last_char)
        else $error("ready while a word is still being sent");

endmodule

bind base73_word_to_text_encoder b73enc_chk u_b73enc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_word_value (i_word_value),
    .i_pad_full   (i_pad_full),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_char   (o_out_char),
    .o_last_char  (o_last_char),
    .o_overflow   (o_overflow)
);
